// ===== rtl/xcpd_pkg.sv =====
// shared types and constants for the xor checked packet deframer
// no dependencies; used by every module of the block except xcpd_ram

package xcpd_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam logic [7:0] START_BYTE_RST = 8'd170;

    // frame descriptor handed from the parser to the emitter
    typedef struct packed {
        logic [7:0] frame_type;
        logic [6:0] frame_length;
    } t_desc;

    typedef enum logic [4:0] {
        PH_HUNT  = 5'b00001,
        PH_LEN   = 5'b00010,
        PH_TYPE  = 5'b00100,
        PH_DATA  = 5'b01000,
        PH_CHECK = 5'b10000
    } t_phase;

endpackage

// ===== rtl/xor_checked_packet_deframer.sv =====
// top level of the xor checked packet deframer
// depends on xcpd_pkg, xcpd_front, xcpd_desc_fifo, xcpd_back, xcpd_ram

// Receives one serial byte per transfer and finds frames laid out as start
// byte, length, type, payload, checksum (XOR of length, type and payload).
// Every frame with a good checksum comes out as one result per payload byte,
// or as a single result with has_data clear for an empty frame, last set on
// the final one. Input bytes are taken one per cycle; the parser stalls
// input only while two validated frames are still waiting to be emitted,
// since the payload ram holds two banks of MAX_PAYLOAD bytes, one per queued
// frame. Results leave at one per cycle unless i_stall holds them; the first
// follows the checksum transfer via the descriptor queue, the registered ram
// read and the result register. start_byte is written via the always-ready cfg channel.

module xor_checked_packet_deframer #(
    parameter int MAX_PAYLOAD = xcpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_frame_type,
    output logic [6:0] o_frame_length,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_has_data,
    output logic       o_last
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = $clog2(2 * MAX_PAYLOAD);

    logic              w_accept, w_push, w_pop, w_empty, w_full;
    logic              w_wr_bank, w_rd_bank;
    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [7:0]        w_wdata, w_rdata;
    xcpd_pkg::t_desc   w_desc, w_head;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = w_full;
    assign w_accept    = i_valid && !w_full;

    xcpd_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W),
        .ADDR_W      (ADDR_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .i_bank     (w_wr_bank),
        .o_push     (w_push),
        .o_desc     (w_desc),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata)
    );

    xcpd_desc_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_desc    (w_desc),
        .i_pop     (w_pop),
        .o_head    (w_head),
        .o_empty   (w_empty),
        .o_full    (w_full),
        .o_wr_bank (w_wr_bank),
        .o_rd_bank (w_rd_bank)
    );

    xcpd_ram #(
        .WIDTH (8),
        .DEPTH (2 * MAX_PAYLOAD)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    xcpd_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .LEN_W       (LEN_W),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_empty        (w_empty),
        .i_bank         (w_rd_bank),
        .o_pop          (w_pop),
        .o_re           (w_re),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_frame_type   (o_frame_type),
        .o_frame_length (o_frame_length),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_has_data     (o_has_data),
        .o_last         (o_last)
    );

    // a validated frame never arrives when both banks are taken
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full)) else $error("descriptor push while queue full");

    // emitter only retires a frame that is queued
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty)) else $error("descriptor pop while queue empty");

    // an empty-frame result is always the only one of its frame
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_data) |-> (o_last && o_frame_length == 7'd0
            && o_payload_byte == 8'd0))
        else $error("empty-frame result malformed");

    // parser never writes into the bank the emitter is reading
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !w_empty) |-> (w_wr_bank != w_rd_bank))
        else $error("payload write into bank under emission");

endmodule

// ===== rtl/xcpd_ram.sv =====
// generic simple dual port ram with one write port and a registered read port
// no dependencies

module xcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/xcpd_front.sv =====
// frame parser: hunts for the start byte, checks length and checksum,
// writes payload into the ram bank it is given. depends on xcpd_pkg

module xcpd_front #(
    parameter int MAX_PAYLOAD = xcpd_pkg::MAX_PAYLOAD_DEF,
    parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    parameter int ADDR_W      = $clog2(2 * MAX_PAYLOAD)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_accept,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_bank,
    output logic                o_push,
    output xcpd_pkg::t_desc     o_desc,
    output logic                o_we,
    output logic [ADDR_W-1:0]   o_waddr,
    output logic [7:0]          o_wdata
);

    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

    xcpd_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_start;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_seen, n_seen;
    logic [7:0]       r_type, n_type;
    logic [7:0]       r_xor, n_xor;
    logic [LEN_W:0]   w_sum;

    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_seen  = r_seen;
        n_type  = r_type;
        n_xor   = r_xor;
        o_push  = 1'b0;
        o_we    = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                xcpd_pkg::PH_LEN: begin
                    if (i_rx_byte > MAX_B) begin
                        // an oversize length equal to the start byte reopens a frame
                        n_phase = (i_rx_byte == r_start) ? xcpd_pkg::PH_LEN
                                                         : xcpd_pkg::PH_HUNT;
                    end else begin
                        n_len   = LEN_W'(i_rx_byte);
                        n_xor   = i_rx_byte;
                        n_phase = xcpd_pkg::PH_TYPE;
                    end
                end
                xcpd_pkg::PH_TYPE: begin
                    n_type  = i_rx_byte;
                    n_xor   = r_xor ^ i_rx_byte;
                    n_seen  = '0;
                    n_phase = (r_len == '0) ? xcpd_pkg::PH_CHECK : xcpd_pkg::PH_DATA;
                end
                xcpd_pkg::PH_DATA: begin
                    o_we   = 1'b1;
                    n_xor  = r_xor ^ i_rx_byte;
                    n_seen = LEN_W'(r_seen + 1'b1);
                    if (n_seen == r_len) begin
                        n_phase = xcpd_pkg::PH_CHECK;
                    end
                end
                xcpd_pkg::PH_CHECK: begin
                    o_push  = (i_rx_byte == r_xor);
                    n_phase = xcpd_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = (i_rx_byte == r_start) ? xcpd_pkg::PH_LEN
                                                     : xcpd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= xcpd_pkg::PH_HUNT;
            r_start <= xcpd_pkg::START_BYTE_RST;
            r_len   <= '0;
            r_seen  <= '0;
            r_type  <= '0;
            r_xor   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_type  <= n_type;
            r_xor   <= n_xor;
            if (i_cfg_we) begin
                r_start <= i_cfg_data;
            end
        end
    end

    // bank one sits above bank zero in the ram
    assign w_sum   = {1'b0, r_seen} + (i_bank ? (LEN_W + 1)'(MAX_PAYLOAD) : '0);
    assign o_waddr = ADDR_W'(w_sum);
    assign o_wdata = i_rx_byte;

    assign o_desc.frame_type   = r_type;
    assign o_desc.frame_length = 7'(r_len);

endmodule

// ===== rtl/xcpd_desc_fifo.sv =====
// two entry queue of validated frame descriptors; entry slot doubles as
// the payload bank number. depends on xcpd_pkg

module xcpd_desc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  xcpd_pkg::t_desc i_desc,
    input  logic            i_pop,
    output xcpd_pkg::t_desc o_head,
    output logic            o_empty,
    output logic            o_full,
    output logic            o_wr_bank,
    output logic            o_rd_bank
);

    xcpd_pkg::t_desc r_ent [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head    = r_ent[r_rd];
    assign o_empty   = (r_count == 2'd0);
    assign o_full    = (r_count == 2'd2);
    assign o_wr_bank = r_wr;
    assign o_rd_bank = r_rd;

endmodule

// ===== rtl/xcpd_back.sv =====
// frame emitter: walks the head descriptor, reads payload from the ram and
// drives the result register. depends on xcpd_pkg

module xcpd_back #(
    parameter int MAX_PAYLOAD = xcpd_pkg::MAX_PAYLOAD_DEF,
    parameter int LEN_W       = $clog2(MAX_PAYLOAD + 1),
    parameter int ADDR_W      = $clog2(2 * MAX_PAYLOAD)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  xcpd_pkg::t_desc   i_head,
    input  logic              i_empty,
    input  logic              i_bank,
    output logic              o_pop,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    input  logic [7:0]        i_rdata,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_frame_type,
    output logic [6:0]        o_frame_length,
    output logic [5:0]        o_byte_index,
    output logic [7:0]        o_payload_byte,
    output logic              o_has_data,
    output logic              o_last
);

    logic [LEN_W-1:0] r_idx;

    // read stage: ram data lands together with these
    logic             r_a_valid;
    logic [7:0]       r_a_type;
    logic [6:0]       r_a_len;
    logic [LEN_W-1:0] r_a_idx;
    logic             r_a_has;
    logic             r_a_last;

    // result register
    logic             r_b_valid;
    logic [7:0]       r_b_type;
    logic [6:0]       r_b_len;
    logic [5:0]       r_b_idx;
    logic [7:0]       r_b_data;
    logic             r_b_has;
    logic             r_b_last;

    logic           w_a_move, w_issue, w_has, w_last;
    logic [LEN_W:0] w_sum;

    assign w_a_move = r_a_valid && (!r_b_valid || !i_stall);
    assign w_issue  = !i_empty && (!r_a_valid || w_a_move);
    assign w_has    = (i_head.frame_length != 7'd0);
    assign w_last   = !w_has || ((7'(r_idx) + 7'd1) == i_head.frame_length);

    assign o_pop = w_issue && w_last;
    // read enable only on issue so a held read stage keeps its data
    assign o_re  = w_issue && w_has;

    assign w_sum   = {1'b0, r_idx} + (i_bank ? (LEN_W + 1)'(MAX_PAYLOAD) : '0);
    assign o_raddr = ADDR_W'(w_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_issue) begin
                r_idx <= w_last ? '0 : LEN_W'(r_idx + 1'b1);
            end
            if (w_issue) begin
                r_a_valid <= 1'b1;
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_move) begin
                r_b_valid <= 1'b1;
            end else if (!i_stall) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_a_type <= i_head.frame_type;
            r_a_len  <= i_head.frame_length;
            r_a_idx  <= r_idx;
            r_a_has  <= w_has;
            r_a_last <= w_last;
        end
        if (w_a_move) begin
            r_b_type <= r_a_type;
            r_b_len  <= r_a_len;
            r_b_idx  <= 6'(r_a_idx);
            r_b_data <= r_a_has ? i_rdata : 8'd0;
            r_b_has  <= r_a_has;
            r_b_last <= r_a_last;
        end
    end

    assign o_valid        = r_b_valid;
    assign o_frame_type   = r_b_type;
    assign o_frame_length = r_b_len;
    assign o_byte_index   = r_b_idx;
    assign o_payload_byte = r_b_data;
    assign o_has_data     = r_b_has;
    assign o_last         = r_b_last;

endmodule
